// ===== rtl/kmr_pkg.sv =====
// Package for the keypad matrix remap table: opcodes, status codes, state codes
// and the item that walks along the row of table cells.
// No dependencies.
`default_nettype none

package kmr_pkg;

  localparam int unsigned DefTableEntries = 32;
  localparam int unsigned KeyRows         = 3;
  localparam int unsigned KeyCols         = 4;
  localparam int unsigned KeyBits         = KeyRows * KeyCols;

  localparam int unsigned OpW   = 2;
  localparam int unsigned RawW  = 12;
  localparam int unsigned MaskW = 32;
  localparam int unsigned StW   = 2;

  // Raw key bits above the matrix are ignored.
  localparam logic [RawW-1:0] KeyMask =
      (KeyBits >= RawW) ? {RawW{1'b1}} : RawW'((64'd1 << KeyBits) - 64'd1);

  typedef enum logic [OpW-1:0] {
    OP_TRANSLATE = 2'd0,
    OP_ADD       = 2'd1,
    OP_DELETE    = 2'd2,
    OP_CLEAR     = 2'd3
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WALK = 2'd1,
    S_DONE = 2'd2
  } state_e;

  // Item handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic             active;
    op_e              op;
    logic [RawW-1:0]  keys;
    logic [MaskW-1:0] key;
    logic [MaskW-1:0] acc;
    logic             found;
  } tok_t;

  // Broadcast write of a new entry.
  typedef struct packed {
    logic             en;
    logic [MaskW-1:0] src;
    logic [MaskW-1:0] tgt;
  } add_t;

endpackage

`default_nettype wire

// ===== rtl/kmr_if.sv =====
// Valid/ready channel interfaces for the keypad matrix remap table.
// Depends on kmr_pkg for the field widths.
`default_nettype none

interface kmr_in_if;
  logic                         valid;
  logic                         ready;
  logic [kmr_pkg::OpW-1:0]      opcode;
  logic [kmr_pkg::RawW-1:0]     raw_keys;
  logic [kmr_pkg::MaskW-1:0]    entry_source_mask;
  logic [kmr_pkg::MaskW-1:0]    entry_target_mask;

  modport source (output valid, opcode, raw_keys, entry_source_mask, entry_target_mask,
                  input ready);
  modport sink   (input valid, opcode, raw_keys, entry_source_mask, entry_target_mask,
                  output ready);
endinterface

interface kmr_out_if;
  logic                         valid;
  logic                         ready;
  logic [kmr_pkg::MaskW-1:0]    mapped_buttons;
  logic [kmr_pkg::RawW-1:0]     raw_buttons;
  logic [kmr_pkg::StW-1:0]      status;

  modport source (output valid, mapped_buttons, raw_buttons, status, input ready);
  modport sink   (input valid, mapped_buttons, raw_buttons, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/kmr_cell.sv =====
// One table cell: holds one entry, processes the walking item and registers it for the next cell.
// Depends on kmr_pkg.
`default_nettype none

module kmr_cell #(
  parameter int unsigned TableEntries = kmr_pkg::DefTableEntries,
  parameter int unsigned Idx          = 0
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire [$clog2(TableEntries+1)-1:0] count_i,
  input  wire kmr_pkg::tok_t             tok_i,
  output kmr_pkg::tok_t                  tok_o,
  input  wire kmr_pkg::add_t             add_i,
  input  wire [kmr_pkg::MaskW-1:0]       nxt_src_i,
  input  wire [kmr_pkg::MaskW-1:0]       nxt_tgt_i,
  output logic [kmr_pkg::MaskW-1:0]      src_o,
  output logic [kmr_pkg::MaskW-1:0]      tgt_o
);

  localparam int unsigned CntW = $clog2(TableEntries + 1);

  logic [kmr_pkg::MaskW-1:0] src_q, tgt_q;
  logic                      act_q;
  kmr_pkg::tok_t             tok_d, tok_q;
  logic                      held, match, shift;

  always_comb begin
    held  = CntW'(Idx) < count_i;
    match = held && (src_q == tok_i.key);
    shift = tok_i.active && (tok_i.op == kmr_pkg::OP_DELETE) && (tok_i.found || match);
    tok_d = tok_i;
    if (tok_i.op == kmr_pkg::OP_TRANSLATE) begin
      if (held && (|(src_q[kmr_pkg::RawW-1:0] & tok_i.keys))) begin
        tok_d.acc = tok_i.acc | tgt_q;
      end
    end else if (tok_i.op == kmr_pkg::OP_DELETE) begin
      tok_d.found = tok_i.found || match;
    end
  end

  // The cell holding the first equal entry and every later cell take their
  // right neighbor's entry, which the item has not reached yet.
  always_ff @(posedge clk_i) begin
    if (add_i.en && (count_i == CntW'(Idx))) begin
      src_q <= add_i.src;
      tgt_q <= add_i.tgt;
    end else if (shift) begin
      src_q <= nxt_src_i;
      tgt_q <= nxt_tgt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= tok_i.active;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o        = tok_q;
    tok_o.active = act_q;
  end

  assign src_o = src_q;
  assign tgt_o = tgt_q;

endmodule

`default_nettype wire

// ===== rtl/keypad_matrix_remap_table_unit.sv =====
// Top level of the keypad matrix remap table: control, entry count, row of
// cells and output register. Depends on kmr_pkg, kmr_if and kmr_cell.
`default_nettype none

// The table is a row of TableEntries cells, one entry per cell. Translate and
// delete items walk the row one cell per cycle and the control waits for them
// in the walk state; add and clear go straight to the done state. One item is
// in the block at a time, and the next is accepted as soon as the previous
// result has moved to the output register, even if that result has not been
// taken yet. There is no clearing pass after reset: only entries below the
// count are ever read.
module keypad_matrix_remap_table_unit #(
  parameter int unsigned TableEntries = kmr_pkg::DefTableEntries
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  kmr_in_if.sink     in_i,
  kmr_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(TableEntries + 1);

  kmr_pkg::state_e           state_q, state_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  kmr_pkg::tok_t             tok [TableEntries+1];
  logic [kmr_pkg::MaskW-1:0] src [TableEntries];
  logic [kmr_pkg::MaskW-1:0] tgt [TableEntries];
  kmr_pkg::add_t             add;
  kmr_pkg::op_e              in_op;
  logic                      accept;

  logic [kmr_pkg::MaskW-1:0] res_map_q, res_map_d;
  logic [kmr_pkg::RawW-1:0]  res_raw_q, res_raw_d;
  kmr_pkg::status_e          res_st_q, res_st_d;

  logic                      ovalid_q, ovalid_d, oload;
  logic [kmr_pkg::MaskW-1:0] omap_q;
  logic [kmr_pkg::RawW-1:0]  oraw_q;
  logic [kmr_pkg::StW-1:0]   ost_q;

  assign in_op    = kmr_pkg::op_e'(in_i.opcode);
  assign in_i.ready = (state_q == kmr_pkg::S_IDLE);
  assign accept   = in_i.valid && in_i.ready;

  always_comb begin
    tok[0].active = accept &&
                    ((in_op == kmr_pkg::OP_TRANSLATE) || (in_op == kmr_pkg::OP_DELETE));
    tok[0].op     = in_op;
    tok[0].keys   = in_i.raw_keys & kmr_pkg::KeyMask;
    tok[0].key    = in_i.entry_source_mask;
    tok[0].acc    = '0;
    tok[0].found  = 1'b0;
  end

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    logic [kmr_pkg::MaskW-1:0] nsrc, ntgt;
    if (g == TableEntries - 1) begin : g_last
      assign nsrc = src[g];
      assign ntgt = tgt[g];
    end else begin : g_mid
      assign nsrc = src[g+1];
      assign ntgt = tgt[g+1];
    end
    kmr_cell #(
      .TableEntries(TableEntries),
      .Idx         (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .count_i  (cnt_q),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .add_i    (add),
      .nxt_src_i(nsrc),
      .nxt_tgt_i(ntgt),
      .src_o    (src[g]),
      .tgt_o    (tgt[g])
    );
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    res_map_d = res_map_q;
    res_raw_d = res_raw_q;
    res_st_d  = res_st_q;
    add.en    = 1'b0;
    add.src   = in_i.entry_source_mask;
    add.tgt   = in_i.entry_target_mask;
    oload     = 1'b0;
    ovalid_d  = ovalid_q && !out_o.ready;
    case (state_q)
      kmr_pkg::S_IDLE: begin
        if (accept) begin
          res_map_d = '0;
          res_raw_d = '0;
          res_st_d  = kmr_pkg::ST_OK;
          case (in_op)
            kmr_pkg::OP_TRANSLATE, kmr_pkg::OP_DELETE: begin
              state_d = kmr_pkg::S_WALK;
            end
            kmr_pkg::OP_ADD: begin
              state_d = kmr_pkg::S_DONE;
              if (cnt_q == CntW'(TableEntries)) begin
                res_st_d = kmr_pkg::ST_FULL;
              end else begin
                add.en = 1'b1;
                cnt_d  = cnt_q + CntW'(1);
              end
            end
            default: begin
              state_d = kmr_pkg::S_DONE;
              cnt_d   = '0;
            end
          endcase
        end
      end
      kmr_pkg::S_WALK: begin
        if (tok[TableEntries].active) begin
          state_d = kmr_pkg::S_DONE;
          if (tok[TableEntries].op == kmr_pkg::OP_TRANSLATE) begin
            res_map_d = tok[TableEntries].acc;
            res_raw_d = tok[TableEntries].keys;
          end else if (tok[TableEntries].found) begin
            cnt_d = cnt_q - CntW'(1);
          end else begin
            res_st_d = kmr_pkg::ST_NOMATCH;
          end
        end
      end
      kmr_pkg::S_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          oload    = 1'b1;
          ovalid_d = 1'b1;
          state_d  = kmr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = kmr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= kmr_pkg::S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_map_q <= res_map_d;
    res_raw_q <= res_raw_d;
    res_st_q  <= res_st_d;
    if (oload) begin
      omap_q <= res_map_q;
      oraw_q <= res_raw_q;
      ost_q  <= res_st_q;
    end
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.mapped_buttons = omap_q;
  assign out_o.raw_buttons    = oraw_q;
  assign out_o.status         = ost_q;

  // The count never exceeds the table size.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TableEntries))
    else $error("entry count above table size");

  // A walking item only leaves the row while the control waits for it.
  a_tail_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[TableEntries].active |-> state_q == kmr_pkg::S_WALK)
    else $error("item left the cell row outside the walk state");

  // An add into a full table reports full and leaves the count alone.
  a_add_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_op == kmr_pkg::OP_ADD && cnt_q == CntW'(TableEntries)
    |=> res_st_q == kmr_pkg::ST_FULL && $stable(cnt_q))
    else $error("add to full table mishandled");

  // A successful delete removes exactly one entry.
  a_del_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == kmr_pkg::S_WALK && tok[TableEntries].active &&
    tok[TableEntries].op == kmr_pkg::OP_DELETE && tok[TableEntries].found
    |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("delete did not drop the count by one");

endmodule

`default_nettype wire
